// ----- rtl/keyword_lexer_macros.svh -----
// assertion macros for the keyword lexer checker
// expects a clock i_clk and an active-low reset i_rst_n in the using scope
`ifndef KEYWORD_LEXER_MACROS_SVH
`define KEYWORD_LEXER_MACROS_SVH

// same-cycle implication, quiet while reset is held
`define KL_ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication, quiet while reset is held
`define KL_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ----- rtl/kl_pkg.sv -----
// shared types and constants of the keyword lexer
// no dependencies
package kl_pkg;

    // token kinds
    localparam logic [4:0] KIND_END     = 5'd0;
    localparam logic [4:0] KIND_ILLEGAL = 5'd1;
    localparam logic [4:0] KIND_INT     = 5'd2;
    localparam logic [4:0] KIND_NAME    = 5'd3;
    localparam logic [4:0] KIND_ASSIGN  = 5'd4;
    localparam logic [4:0] KIND_PLUS    = 5'd5;
    localparam logic [4:0] KIND_MINUS   = 5'd6;
    localparam logic [4:0] KIND_STAR    = 5'd7;
    localparam logic [4:0] KIND_SLASH   = 5'd8;
    localparam logic [4:0] KIND_EQEQ    = 5'd9;
    localparam logic [4:0] KIND_NE      = 5'd10;
    localparam logic [4:0] KIND_LT      = 5'd11;
    localparam logic [4:0] KIND_GT      = 5'd12;
    localparam logic [4:0] KIND_SEMI    = 5'd13;
    localparam logic [4:0] KIND_LPAREN  = 5'd14;
    localparam logic [4:0] KIND_RPAREN  = 5'd15;
    localparam logic [4:0] KIND_LBRACE  = 5'd16;
    localparam logic [4:0] KIND_RBRACE  = 5'd17;
    localparam logic [4:0] KIND_COMMA   = 5'd18;
    localparam logic [4:0] KIND_LET     = 5'd19;
    localparam logic [4:0] KIND_IF      = 5'd20;
    localparam logic [4:0] KIND_ELSE    = 5'd21;
    localparam logic [4:0] KIND_WHILE   = 5'd22;
    localparam logic [4:0] KIND_FN      = 5'd23;
    localparam logic [4:0] KIND_RETURN  = 5'd24;

    // characters with a role of their own
    localparam logic [7:0] CH_NUL        = 8'h00;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_EQUAL      = 8'h3D;
    localparam logic [7:0] CH_BANG       = 8'h21;

    localparam int PREFIX_CHARS = 8;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic [15:0] POS_MAX = 16'hFFFF;
    localparam logic [6:0]  LEN_MAX = 7'd127;

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] line;
        logic [15:0] column;
        logic [63:0] text;
        logic [6:0]  length;
        logic [31:0] number;
        logic        overflow;
        logic        last;
    } t_token;

endpackage

// ----- rtl/keyword_lexer.sv -----
// keyword lexer: one source byte in per cycle unless stalled, tokens out through a queue
// a token passes through the queue memory and then the output register to the outputs
// a byte that closes a token and also makes one stalls the byte input (o_ready low)
// while the front end pushes its held second token; a full queue also stalls the input
// reset: synchronous, active low; line 1, column 0, no token held, queue and output empty
// depends on kl_pkg, kl_front, kl_queue and kl_back
module keyword_lexer #(
    parameter int P_QUEUE_DEPTH = kl_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_char_code,
    // token channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [4:0]  o_token_kind,
    output logic [15:0] o_line,
    output logic [15:0] o_column,
    output logic [63:0] o_text_prefix,
    output logic [6:0]  o_text_length,
    output logic [31:0] o_number_value,
    output logic        o_number_overflow,
    output logic        o_last
);
    // front end -> queue
    logic           push;
    kl_pkg::t_token push_token;
    // queue -> output stage
    logic           pop;
    logic           q_full;
    logic           q_empty;
    kl_pkg::t_token q_head;
    kl_pkg::t_token out_token;

    // front end: classifies each byte, keeps line and column, builds the token
    // in flight, and emits closed tokens; keyword names are left for the back end
    kl_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_char_code  (i_char_code),
        .i_full       (q_full),
        .o_push       (push),
        .o_push_token (push_token)
    );

    // short queue so a stalled consumer does not stop the byte stream at once
    kl_queue #(
        .DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_token (push_token),
        .i_pop        (pop),
        .o_head       (q_head),
        .o_full       (q_full),
        .o_empty      (q_empty)
    );

    // back end: keyword match on names, then the output register
    kl_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_token (q_head),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_token (out_token)
    );

    // unpack the result register onto the field ports
    assign o_token_kind      = out_token.kind;
    assign o_line            = out_token.line;
    assign o_column          = out_token.column;
    assign o_text_prefix     = out_token.text;
    assign o_text_length     = out_token.length;
    assign o_number_value    = out_token.number;
    assign o_number_overflow = out_token.overflow;
    assign o_last            = out_token.last;

endmodule

// ----- rtl/kl_queue.sv -----
// token queue between the lexer front end and the output stage
// depends on kl_pkg for the token type
module kl_queue #(
    parameter int DEPTH = kl_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  kl_pkg::t_token i_push_token,
    input  logic           i_pop,
    output kl_pkg::t_token o_head,
    output logic           o_full,
    output logic           o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    kl_pkg::t_token r_mem [DEPTH];
    logic [AW-1:0]  r_wr, n_wr;
    logic [AW-1:0]  r_rd, n_rd;
    logic [AW:0]    r_count, n_count;
    logic           do_push, do_pop;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push_token;
        end
    end

endmodule

// ----- rtl/kl_front.sv -----
// lexer front end: takes bytes, tracks position and the pending token
// depends on kl_pkg; feeds kl_queue one token per cycle while the queue is not full
module kl_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_char_code,
    input  logic           i_full,
    output logic           o_push,
    output kl_pkg::t_token o_push_token
);
    localparam logic [2:0] MODE_IDLE = 3'd0;
    localparam logic [2:0] MODE_NAME = 3'd1;
    localparam logic [2:0] MODE_NUM  = 3'd2;
    localparam logic [2:0] MODE_EQ   = 3'd3;
    localparam logic [2:0] MODE_BANG = 3'd4;

    logic [2:0]     r_mode,  n_mode;
    logic [15:0]    r_line,  n_line;
    logic [15:0]    r_col,   n_col;
    logic [15:0]    r_sline, n_sline;
    logic [15:0]    r_scol,  n_scol;
    logic [63:0]    r_text,  n_text;
    logic [6:0]     r_len,   n_len;
    logic [31:0]    r_num,   n_num;
    logic           r_ovf,   n_ovf;
    logic           r_pend_valid, n_pend_valid;
    kl_pkg::t_token r_pend,  n_pend;

    logic           acc, cont, has_a, has_b;
    logic           is_alpha, is_digit, is_space;
    logic [15:0]    col;
    logic [35:0]    num_next;
    logic [4:0]     single;
    kl_pkg::t_token tok_a, tok_b;

    function automatic logic [4:0] single_kind(input logic [7:0] c);
        logic [4:0] k;
        case (c)
            8'h2B:   k = kl_pkg::KIND_PLUS;
            8'h2D:   k = kl_pkg::KIND_MINUS;
            8'h2A:   k = kl_pkg::KIND_STAR;
            8'h2F:   k = kl_pkg::KIND_SLASH;
            8'h3C:   k = kl_pkg::KIND_LT;
            8'h3E:   k = kl_pkg::KIND_GT;
            8'h3B:   k = kl_pkg::KIND_SEMI;
            8'h28:   k = kl_pkg::KIND_LPAREN;
            8'h29:   k = kl_pkg::KIND_RPAREN;
            8'h7B:   k = kl_pkg::KIND_LBRACE;
            8'h7D:   k = kl_pkg::KIND_RBRACE;
            8'h2C:   k = kl_pkg::KIND_COMMA;
            default: k = kl_pkg::KIND_ILLEGAL;
        endcase
        return k;
    endfunction

    // append a byte to the held text prefix
    function automatic logic [63:0] hold_text(input logic [63:0] text, input logic [6:0] len,
                                              input logic [7:0] c);
        logic [63:0] t;
        t = text;
        for (int i = 0; i < 8; i++) begin
            if (i < kl_pkg::PREFIX_CHARS && len == 7'(i)) begin
                t[8*i +: 8] = c;
            end
        end
        return t;
    endfunction

    assign acc      = i_valid && o_ready;
    assign o_ready  = !r_pend_valid && !i_full;
    assign is_alpha = (i_char_code >= 8'h61 && i_char_code <= 8'h7A) ||
                      (i_char_code >= 8'h41 && i_char_code <= 8'h5A) ||
                      (i_char_code == kl_pkg::CH_UNDERSCORE);
    assign is_digit = (i_char_code >= 8'h30 && i_char_code <= 8'h39);
    assign is_space = (i_char_code == 8'h20) ||
                      (i_char_code >= 8'h09 && i_char_code <= 8'h0D);
    assign col      = (r_col < kl_pkg::POS_MAX) ? r_col + 16'd1 : kl_pkg::POS_MAX;
    assign num_next = ({4'd0, r_num} << 3) + ({4'd0, r_num} << 1) +
                      36'(i_char_code - 8'h30);
    assign single   = single_kind(i_char_code);

    always_comb begin
        n_mode  = r_mode;
        n_line  = r_line;
        n_col   = r_col;
        n_sline = r_sline;
        n_scol  = r_scol;
        n_text  = r_text;
        n_len   = r_len;
        n_num   = r_num;
        n_ovf   = r_ovf;
        cont    = 1'b0;
        has_a   = 1'b0;
        has_b   = 1'b0;

        tok_a          = '0;
        tok_a.line     = r_sline;
        tok_a.column   = r_scol;
        tok_b          = '0;
        tok_b.line     = r_line;
        tok_b.column   = col;
        tok_b.last     = 1'b1;

        if (acc) begin
            // held token: extend it or close it
            case (r_mode)
                MODE_NAME: begin
                    if (is_alpha || is_digit) begin
                        cont   = 1'b1;
                        n_text = hold_text(r_text, r_len, i_char_code);
                        n_len  = (r_len < kl_pkg::LEN_MAX) ? r_len + 7'd1 : r_len;
                    end else begin
                        has_a        = 1'b1;
                        tok_a.kind   = kl_pkg::KIND_NAME;
                        tok_a.text   = r_text;
                        tok_a.length = r_len;
                        n_mode       = MODE_IDLE;
                    end
                end
                MODE_NUM: begin
                    if (is_digit) begin
                        cont   = 1'b1;
                        n_text = hold_text(r_text, r_len, i_char_code);
                        n_len  = (r_len < kl_pkg::LEN_MAX) ? r_len + 7'd1 : r_len;
                        if (r_ovf || num_next[35:32] != 4'd0) begin
                            n_num = 32'hFFFF_FFFF;
                            n_ovf = 1'b1;
                        end else begin
                            n_num = num_next[31:0];
                        end
                    end else begin
                        has_a          = 1'b1;
                        tok_a.kind     = kl_pkg::KIND_INT;
                        tok_a.text     = r_text;
                        tok_a.length   = r_len;
                        tok_a.number   = r_num;
                        tok_a.overflow = r_ovf;
                        n_mode         = MODE_IDLE;
                    end
                end
                MODE_EQ, MODE_BANG: begin
                    has_a  = 1'b1;
                    n_mode = MODE_IDLE;
                    if (i_char_code == kl_pkg::CH_EQUAL) begin
                        cont         = 1'b1;
                        tok_a.kind   = (r_mode == MODE_EQ) ? kl_pkg::KIND_EQEQ
                                                           : kl_pkg::KIND_NE;
                        tok_a.text   = {48'd0, kl_pkg::CH_EQUAL,
                                        (r_mode == MODE_EQ) ? kl_pkg::CH_EQUAL
                                                            : kl_pkg::CH_BANG};
                        tok_a.length = 7'd2;
                    end else begin
                        tok_a.kind   = (r_mode == MODE_EQ) ? kl_pkg::KIND_ASSIGN
                                                           : kl_pkg::KIND_ILLEGAL;
                        tok_a.text   = {56'd0, (r_mode == MODE_EQ) ? kl_pkg::CH_EQUAL
                                                                   : kl_pkg::CH_BANG};
                        tok_a.length = 7'd1;
                    end
                end
                default: begin
                    n_mode = MODE_IDLE;
                end
            endcase

            // the byte itself, seen from between tokens
            if (!cont) begin
                if (i_char_code == kl_pkg::CH_NUL) begin
                    has_b      = 1'b1;
                    tok_b.kind = kl_pkg::KIND_END;
                end else if (is_space) begin
                    n_mode = MODE_IDLE;
                end else if (i_char_code == kl_pkg::CH_EQUAL ||
                             i_char_code == kl_pkg::CH_BANG || is_alpha || is_digit) begin
                    n_sline = r_line;
                    n_scol  = col;
                    n_ovf   = 1'b0;
                    n_text  = '0;
                    n_len   = '0;
                    n_num   = '0;
                    if (i_char_code == kl_pkg::CH_EQUAL) begin
                        n_mode = MODE_EQ;
                    end else if (i_char_code == kl_pkg::CH_BANG) begin
                        n_mode = MODE_BANG;
                    end else begin
                        n_mode = is_alpha ? MODE_NAME : MODE_NUM;
                        n_text = {56'd0, i_char_code};
                        n_len  = 7'd1;
                        if (is_digit) begin
                            n_num = 32'(i_char_code - 8'h30);
                        end
                    end
                end else begin
                    has_b        = 1'b1;
                    tok_b.kind   = single;
                    tok_b.text   = {56'd0, i_char_code};
                    tok_b.length = 7'd1;
                end
            end

            tok_a.last = !has_b;

            if (!cont && i_char_code == kl_pkg::CH_NUL) begin
                n_line = 16'd1;
                n_col  = 16'd0;
            end else if (i_char_code == kl_pkg::CH_NEWLINE) begin
                n_line = (r_line < kl_pkg::POS_MAX) ? r_line + 16'd1 : kl_pkg::POS_MAX;
                n_col  = 16'd0;
            end else begin
                n_col = col;
            end
        end
    end

    // one push per cycle; a second token waits in the holding register
    always_comb begin
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        if (r_pend_valid) begin
            o_push       = !i_full;
            o_push_token = r_pend;
            n_pend_valid = i_full;
        end else begin
            o_push       = acc && (has_a || has_b);
            o_push_token = has_a ? tok_a : tok_b;
            if (acc && has_a && has_b) begin
                n_pend_valid = 1'b1;
                n_pend       = tok_b;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_IDLE;
            r_line       <= 16'd1;
            r_col        <= 16'd0;
            r_sline      <= 16'd1;
            r_scol       <= 16'd1;
            r_text       <= '0;
            r_len        <= '0;
            r_num        <= '0;
            r_ovf        <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_mode       <= n_mode;
            r_line       <= n_line;
            r_col        <= n_col;
            r_sline      <= n_sline;
            r_scol       <= n_scol;
            r_text       <= n_text;
            r_len        <= n_len;
            r_num        <= n_num;
            r_ovf        <= n_ovf;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
    end

endmodule

// ----- rtl/kl_back.sv -----
// output stage: resolves keywords and holds the result register
// depends on kl_pkg; pops tokens from kl_queue
module kl_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  kl_pkg::t_token i_token,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output kl_pkg::t_token o_token
);
    logic           r_valid;
    kl_pkg::t_token r_token;
    kl_pkg::t_token resolved;

    function automatic logic [4:0] name_kind(input logic [63:0] text, input logic [6:0] len);
        logic [4:0] k;
        k = kl_pkg::KIND_NAME;
        if (len == 7'd3 && text == 64'h0000_0000_0074_656C) begin
            k = kl_pkg::KIND_LET;
        end else if (len == 7'd2 && text == 64'h0000_0000_0000_6669) begin
            k = kl_pkg::KIND_IF;
        end else if (len == 7'd4 && text == 64'h0000_0000_6573_6C65) begin
            k = kl_pkg::KIND_ELSE;
        end else if (len == 7'd5 && text == 64'h0000_0065_6C69_6877) begin
            k = kl_pkg::KIND_WHILE;
        end else if (len == 7'd2 && text == 64'h0000_0000_0000_6E66) begin
            k = kl_pkg::KIND_FN;
        end else if (len == 7'd6 && text == 64'h0000_6E72_7574_6572) begin
            k = kl_pkg::KIND_RETURN;
        end
        return k;
    endfunction

    always_comb begin
        resolved = i_token;
        if (i_token.kind == kl_pkg::KIND_NAME) begin
            resolved.kind = name_kind(i_token.text, i_token.length);
        end
    end

    assign o_pop   = !i_empty && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_token = r_token;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_token <= resolved;
        end
    end

endmodule

// ----- rtl/kl_checker.sv -----
// port-level checks on the keyword lexer outputs, bound to the top level
// depends on kl_pkg and keyword_lexer_macros.svh
`include "keyword_lexer_macros.svh"

module kl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [4:0]  o_token_kind,
    input logic [15:0] o_line,
    input logic [15:0] o_column,
    input logic [63:0] o_text_prefix,
    input logic [6:0]  o_text_length,
    input logic [31:0] o_number_value,
    input logic        o_number_overflow,
    input logic        o_last
);
    // a stalled item keeps its kind and text
    `KL_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_token_kind) && $stable(o_text_prefix), "stalled item changed")

    // end of text closes the byte's results and carries no text
    `KL_ASSERT_IMPL(a_end_shape, o_valid && o_token_kind == kl_pkg::KIND_END, o_last && o_text_length == 7'd0 && o_text_prefix == 64'd0, "malformed end item")

    // only integers carry a value
    `KL_ASSERT_IMPL(a_num_only_int, o_valid && o_token_kind != kl_pkg::KIND_INT, o_number_value == 32'd0 && !o_number_overflow, "value on a non-integer item")

    // a saturated integer reads all ones
    `KL_ASSERT_IMPL(a_ovf_sat, o_valid && o_number_overflow, o_number_value == 32'hFFFF_FFFF, "overflow without saturated value")

    // positions are one-based
    `KL_ASSERT_IMPL(a_pos_nonzero, o_valid, o_line != 16'd0 && o_column != 16'd0, "zero line or column")

endmodule

bind keyword_lexer kl_checker u_kl_checker (.*);
